// ----- design/name_to_id_registry_table_defines.svh -----
// assertion macros for the name to id registry table
`ifndef NAME_TO_ID_REGISTRY_TABLE_DEFINES_SVH
`define NAME_TO_ID_REGISTRY_TABLE_DEFINES_SVH

`ifndef ASSERT_OFF
`define NTTR_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("nttr assertion failed");
`define NTTR_ASSERT_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("nttr forbidden condition seen");
`else
`define NTTR_ASSERT(label, clk, rstn, prop)
`define NTTR_ASSERT_NEVER(label, clk, rstn, expr)
`endif

`endif

// ----- design/nttr_pkg.sv -----
// shared types and constants of the name to id registry table
package nttr_pkg;

    localparam int BYTE_W     = 8;
    localparam int WORD_BYTES = 8;
    localparam int WORD_W     = BYTE_W * WORD_BYTES;
    localparam int NAME_BYTES = 2 * WORD_BYTES;
    localparam int NAME_W     = 2 * WORD_W;
    localparam int PID_W      = 16;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_REGISTER   = 2'd0,
        CMD_LOOKUP     = 2'd1,
        CMD_UNREGISTER = 2'd2,
        CMD_OTHER      = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_EXISTS   = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_INVALID  = 3'd4
    } status_t;

    // search token handed from cell to cell
    typedef struct packed {
        logic             valid;
        logic             hit;
        logic             free;
        logic [PID_W-1:0] owner;
    } acc_t;

    // request key and update strobes seen by every cell
    typedef struct packed {
        logic              fill;
        logic              clear;
        logic [WORD_W-1:0] key_low;
        logic [WORD_W-1:0] key_high;
        logic [PID_W-1:0]  pid;
    } bcast_t;

endpackage

// ----- design/nttr_cell.sv -----
// one table slot: holds an entry, matches the key and passes the search token on
module nttr_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  nttr_pkg::acc_t   acc_in,
    input  nttr_pkg::bcast_t bcast,
    output nttr_pkg::acc_t   acc_out
);
    import nttr_pkg::*;

    logic              valid_reg;
    logic [WORD_W-1:0] key_low_reg;
    logic [WORD_W-1:0] key_high_reg;
    logic [PID_W-1:0]  owner_reg;
    logic              sel_hit_reg;
    logic              sel_free_reg;
    acc_t              acc_out_reg;
    acc_t              acc_next;
    logic              my_hit;

    assign my_hit = valid_reg && (key_low_reg == bcast.key_low)
                    && (key_high_reg == bcast.key_high);

    always_comb begin
        acc_next.valid = acc_in.valid;
        acc_next.hit   = acc_in.hit || my_hit;
        acc_next.free  = acc_in.free || !valid_reg;
        if (acc_in.hit) begin
            acc_next.owner = acc_in.owner;
        end else if (my_hit) begin
            acc_next.owner = owner_reg;
        end else begin
            acc_next.owner = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg         <= 1'b0;
            sel_hit_reg       <= 1'b0;
            sel_free_reg      <= 1'b0;
            acc_out_reg.valid <= 1'b0;
        end else begin
            acc_out_reg <= acc_next;
            if (acc_in.valid) begin
                sel_hit_reg  <= my_hit && !acc_in.hit;
                sel_free_reg <= !valid_reg && !acc_in.free;
            end
            if (bcast.fill && sel_free_reg) begin
                valid_reg <= 1'b1;
            end else if (bcast.clear && sel_hit_reg) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (bcast.fill && sel_free_reg) begin
            key_low_reg  <= bcast.key_low;
            key_high_reg <= bcast.key_high;
            owner_reg    <= bcast.pid;
        end
    end

    assign acc_out = acc_out_reg;

endmodule

// ----- design/name_to_id_registry_table.sv -----
// top level of the name to id registry table: request control and slot chain
// A request is taken when the block is idle; its name is cut at the first zero
// byte and a search token then walks the chain of ENTRIES slot cells, one cell
// per clock, collecting the match and the lowest free slot. When the token leaves
// the chain its result is registered; once the output register is free, the
// reply is loaded into it together with any fill or clear strobe for the chosen
// slot. A new request is not taken until that reply has been loaded. A waiting
// reply does not block the next request until its own search ends. Slot
// contents need no clearing after reset.
`include "name_to_id_registry_table_defines.svh"

module name_to_id_registry_table #(
    parameter int ENTRIES = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [nttr_pkg::CMD_W-1:0]        s_command,
    input  logic [nttr_pkg::WORD_W-1:0]       s_name_low,
    input  logic [nttr_pkg::WORD_W-1:0]       s_name_high,
    input  logic [nttr_pkg::PID_W-1:0]        s_sender_pid,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [nttr_pkg::STATUS_W-1:0]     m_status,
    output logic [nttr_pkg::PID_W-1:0]        m_found_pid,
    output logic [nttr_pkg::PID_W-1:0]        m_reply_pid
);
    import nttr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    function automatic logic [NAME_W-1:0] canon_name(input logic [NAME_W-1:0] name);
        logic              ended;
        logic [NAME_W-1:0] res;
        ended = 1'b0;
        res   = name;
        for (int b = 0; b < NAME_BYTES; b++) begin
            if (ended) begin
                res[b*BYTE_W +: BYTE_W] = '0;
            end else if (name[b*BYTE_W +: BYTE_W] == '0) begin
                ended = 1'b1;
            end
        end
        return res;
    endfunction

    state_t              state_reg;
    cmd_t                cmd_reg;
    logic [WORD_W-1:0]   key_low_reg;
    logic [WORD_W-1:0]   key_high_reg;
    logic [PID_W-1:0]    pid_reg;
    logic                start_reg;
    acc_t                result_reg;
    logic                fill_reg;
    logic                clear_reg;
    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [PID_W-1:0]    m_found_pid_reg;
    logic [PID_W-1:0]    m_reply_pid_reg;

    acc_t                chain [ENTRIES+1];
    bcast_t              bcast;
    logic [NAME_W-1:0]   name_canon;
    logic                accept;
    logic                out_free;
    status_t             status_next;
    logic [PID_W-1:0]    found_next;
    logic                fill_next;
    logic                clear_next;

    assign name_canon = canon_name({s_name_high, s_name_low});
    assign s_ready    = (state_reg == S_IDLE);
    assign accept     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;

    assign chain[0].valid = start_reg;
    assign chain[0].hit   = 1'b0;
    assign chain[0].free  = 1'b0;
    assign chain[0].owner = '0;

    assign bcast.fill     = fill_reg;
    assign bcast.clear    = clear_reg;
    assign bcast.key_low  = key_low_reg;
    assign bcast.key_high = key_high_reg;
    assign bcast.pid      = pid_reg;

    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        nttr_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .acc_in  (chain[i]),
            .bcast   (bcast),
            .acc_out (chain[i+1])
        );
    end

    always_comb begin
        status_next = ST_INVALID;
        found_next  = '0;
        fill_next   = 1'b0;
        clear_next  = 1'b0;
        case (cmd_reg)
            CMD_REGISTER: begin
                if (result_reg.hit) begin
                    status_next = ST_EXISTS;
                end else if (result_reg.free) begin
                    status_next = ST_OK;
                    fill_next   = 1'b1;
                end else begin
                    status_next = ST_FULL;
                end
            end
            CMD_LOOKUP: begin
                if (result_reg.hit) begin
                    status_next = ST_OK;
                    found_next  = result_reg.owner;
                end else begin
                    status_next = ST_NOTFOUND;
                end
            end
            CMD_UNREGISTER: begin
                if (result_reg.hit) begin
                    status_next = ST_OK;
                    clear_next  = 1'b1;
                end else begin
                    status_next = ST_NOTFOUND;
                end
            end
            default: begin
                status_next = ST_INVALID;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            start_reg   <= 1'b0;
            fill_reg    <= 1'b0;
            clear_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            start_reg <= 1'b0;
            fill_reg  <= 1'b0;
            clear_reg <= 1'b0;
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        cmd_reg      <= cmd_t'(s_command);
                        key_low_reg  <= name_canon[WORD_W-1:0];
                        key_high_reg <= name_canon[NAME_W-1:WORD_W];
                        pid_reg      <= s_sender_pid;
                        start_reg    <= 1'b1;
                        state_reg    <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (chain[ENTRIES].valid) begin
                        result_reg <= chain[ENTRIES];
                        state_reg  <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        m_valid_reg     <= 1'b1;
                        m_status_reg    <= status_next;
                        m_found_pid_reg <= found_next;
                        m_reply_pid_reg <= pid_reg;
                        fill_reg        <= fill_next;
                        clear_reg       <= clear_next;
                        state_reg       <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_found_pid = m_found_pid_reg;
    assign m_reply_pid = m_reply_pid_reg;

    // token leaves the chain only while a search is running
    `NTTR_ASSERT(a_tail_in_scan, aclk, aresetn, chain[ENTRIES].valid |-> (state_reg == S_SCAN))
    // a slot update never fills and clears at once
    `NTTR_ASSERT_NEVER(a_fill_clear, aclk, aresetn, fill_reg && clear_reg)
    // a taken request starts exactly one search token
    `NTTR_ASSERT(a_start_token, aclk, aresetn, accept |=> (start_reg && !s_ready))
    // a new reply is only loaded at the end of a search
    `NTTR_ASSERT(a_reply_src, aclk, aresetn, $rose(m_valid) |-> $past(state_reg == S_DONE))

endmodule
